// File: src/brss_pkg.sv
// Shared types, constants and helper functions of the binary range-sort store.
package brss_pkg;

  localparam int PosW = 10;
  localparam int WordBits = 5;
  localparam int WordW = 32;
  localparam int WordIdxW = PosW - WordBits;
  localparam int CntW = PosW + 1;
  localparam int DefArraySize = 1024;
  localparam logic [31:0] ThresholdReset = 32'd0;
  localparam logic [10:0] UsedLengthReset = 11'd1024;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_SORT  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_kind_t;

  typedef enum logic {
    REG_THRESHOLD   = 1'b0,
    REG_USED_LENGTH = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_Q_RD,
    ST_Q_DATA,
    ST_Q_RESP,
    ST_CNT_RD,
    ST_CNT_ACC,
    ST_SORT_CHK,
    ST_WR_RD,
    ST_WR_WR
  } state_t;

  typedef struct packed {
    logic signed [31:0] threshold;
    logic [10:0]        used_length;
  } cfg_t;

  function automatic logic [WordW-1:0] range_mask(input logic [WordIdxW-1:0] w,
                                                   input logic [PosW-1:0] x,
                                                   input logic [PosW-1:0] y);
    logic [WordW-1:0] m;
    logic [PosW-1:0]  p;
    for (int i = 0; i < WordW; i++) begin
      p = {w, WordBits'(i)};
      m[i] = (p >= x) && (p <= y);
    end
    return m;
  endfunction

  function automatic logic [WordBits:0] pop_count(input logic [WordW-1:0] v);
    logic [WordBits:0] s;
    s = '0;
    for (int i = 0; i < WordW; i++) begin
      s = s + (WordBits+1)'(v[i]);
    end
    return s;
  endfunction

endpackage

// File: src/brss_if.sv
// Request and result channel interfaces of the binary range-sort store.
interface brss_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [9:0]  position;
  logic [9:0]  right_end;
  logic        descending;
  logic signed [31:0] element_value;

  modport source(output valid, req_type, position, right_end, descending, element_value,
                 input ready);
  modport sink(input valid, req_type, position, right_end, descending, element_value,
               output ready);
endinterface

interface brss_out_if;
  logic valid;
  logic ready;
  logic bit_at_position;

  modport source(output valid, bit_at_position, input ready);
  modport sink(input valid, bit_at_position, output ready);
endinterface

// File: src/brss_cfg.sv
// APB-style configuration registers of the binary range-sort store.
module brss_cfg
  import brss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic signed [31:0] thr_r;
  logic [10:0]        len_r;
  reg_idx_t           idx;

  assign idx = reg_idx_t'(paddr[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ThresholdReset;
      len_r <= UsedLengthReset;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_THRESHOLD:   thr_r <= pwdata;
        REG_USED_LENGTH: len_r <= pwdata[10:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THRESHOLD:   prdata = thr_r;
      REG_USED_LENGTH: prdata = {21'd0, len_r};
    endcase
  end

  assign cfg.threshold = thr_r;
  assign cfg.used_length = len_r;

endmodule

// File: src/brss_mem.sv
// Bit-array word memory with one write port and a registered read port.
module brss_mem #(
  parameter int Depth = 32,
  parameter int AddrW = 5,
  parameter int DataW = 32
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [DataW-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [DataW-1:0] rdata
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/brss_ctrl.sv
// Request sequencer that counts and rewrites bit-array words by read-modify-write.
module brss_ctrl
  import brss_pkg::*;
#(
  parameter int ArraySize = DefArraySize,
  parameter int AddrW = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  brss_in_if.sink          in_req,
  brss_out_if.source       out_rsp,
  output logic             mem_we,
  output logic [AddrW-1:0] mem_waddr,
  output logic [WordW-1:0] mem_wdata,
  output logic             mem_re,
  output logic [AddrW-1:0] mem_raddr,
  input  logic [WordW-1:0] mem_rdata
);

  localparam int NumWords = (ArraySize + WordW - 1) / WordW;
  localparam int SzW = $clog2(ArraySize + 1);
  localparam int LenW = (SzW > 11) ? SzW : 11;

  state_t state_r, state_nxt;
  logic [PosW-1:0]     a_r, b_r, oa_r, ob_r;
  logic                desc_r, bit_r, res_r, qbit_r, out_valid_r;
  logic [WordIdxW-1:0] wc_r;
  logic [CntW-1:0]     cnt_r;
  logic [AddrW-1:0]    clr_r;

  logic [LenW-1:0]  len;
  logic             in_acc, pos_ok, sort_ok, cmp_bit, out_free, last_word, uniform;
  logic [PosW-1:0]  rgt_sat;
  logic [CntW-1:0]  width;
  logic [WordW-1:0] m, om;
  req_kind_t        kind;

  assign kind = req_kind_t'(in_req.req_type);
  assign len = (LenW'(cfg.used_length) > LenW'(ArraySize)) ? LenW'(ArraySize)
                                                           : LenW'(cfg.used_length);
  assign pos_ok = LenW'(in_req.position) < len;
  assign rgt_sat = (LenW'(in_req.right_end) >= len) ? PosW'(len - LenW'(1))
                                                    : in_req.right_end;
  assign sort_ok = pos_ok && (in_req.position <= rgt_sat);
  assign cmp_bit = in_req.element_value <= cfg.threshold;
  assign in_req.ready = (state_r == ST_IDLE);
  assign in_acc = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_rsp.ready;
  assign last_word = (wc_r == b_r[PosW-1:WordBits]);
  assign width = CntW'(b_r) - CntW'(a_r) + CntW'(1);
  assign uniform = (cnt_r == '0) || (cnt_r == width);
  assign m = range_mask(wc_r, a_r, b_r);
  assign om = range_mask(wc_r, oa_r, ob_r);
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.bit_at_position = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:    if (clr_r == AddrW'(NumWords - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          unique case (kind)
            REQ_LOAD:  state_nxt = pos_ok ? ST_LD_RD : ST_IDLE;
            REQ_SORT:  state_nxt = sort_ok ? ST_CNT_RD : ST_IDLE;
            REQ_QUERY: state_nxt = pos_ok ? ST_Q_RD : ST_Q_RESP;
            REQ_NONE:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LD_RD:    state_nxt = ST_LD_WR;
      ST_LD_WR:    state_nxt = ST_IDLE;
      ST_Q_RD:     state_nxt = ST_Q_DATA;
      ST_Q_DATA:   state_nxt = ST_Q_RESP;
      ST_Q_RESP:   if (out_free) state_nxt = ST_IDLE;
      ST_CNT_RD:   state_nxt = ST_CNT_ACC;
      ST_CNT_ACC:  state_nxt = last_word ? ST_SORT_CHK : ST_CNT_RD;
      ST_SORT_CHK: state_nxt = uniform ? ST_IDLE : ST_WR_RD;
      ST_WR_RD:    state_nxt = ST_WR_WR;
      ST_WR_WR:    state_nxt = last_word ? ST_IDLE : ST_WR_RD;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = AddrW'(wc_r);
    mem_wdata = mem_rdata;
    mem_re = 1'b0;
    mem_raddr = AddrW'(wc_r);
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      ST_LD_RD, ST_Q_RD, ST_CNT_RD, ST_WR_RD: mem_re = 1'b1;
      ST_LD_WR: begin
        mem_we = 1'b1;
        mem_wdata[a_r[WordBits-1:0]] = bit_r;
      end
      ST_WR_WR: begin
        mem_we = 1'b1;
        mem_wdata = (mem_rdata & ~m) | (om & m);
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + AddrW'(1);
      end
      if (state_r == ST_Q_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        a_r <= in_req.position;
        b_r <= rgt_sat;
        desc_r <= in_req.descending;
        bit_r <= cmp_bit;
        wc_r <= in_req.position[PosW-1:WordBits];
        cnt_r <= '0;
        qbit_r <= 1'b0;
      end
      ST_Q_DATA: qbit_r <= mem_rdata[a_r[WordBits-1:0]];
      ST_Q_RESP: if (out_free) res_r <= qbit_r;
      ST_CNT_ACC: begin
        cnt_r <= cnt_r + CntW'(pop_count(mem_rdata & m));
        if (!last_word) wc_r <= wc_r + WordIdxW'(1);
      end
      ST_SORT_CHK: begin
        wc_r <= a_r[PosW-1:WordBits];
        if (!desc_r) begin
          oa_r <= a_r;
          ob_r <= PosW'(CntW'(a_r) + cnt_r - CntW'(1));
        end else begin
          oa_r <= PosW'(CntW'(b_r) - cnt_r + CntW'(1));
          ob_r <= b_r;
        end
      end
      ST_WR_WR: if (!last_word) wc_r <= wc_r + WordIdxW'(1);
      default: ;
    endcase
  end

endmodule

// File: src/binary_range_sort_store_core.sv
// Binary range-sort store: a bit array in a word memory, with load, range sort and query.
// Each position holds one bit, set on load when the value is at most the threshold. The
// bits live in a memory of 32-bit words; loads and range sorts are done by read-modify-write
// of whole words through one read and one write port, and a query reads one word. A query
// result may wait for the result channel. A range sort makes one pass over its words that
// counts the ones and, unless the range is all zeros or all ones, a second pass that
// rewrites them. After reset a clearing pass zeroes the memory while no request is taken;
// configuration writes are taken at any time.
module binary_range_sort_store_core
  import brss_pkg::*;
#(
  parameter int ARRAY_SIZE = DefArraySize
) (
  input  logic        clk,
  input  logic        rst_n,
  brss_in_if.sink     in_req,
  brss_out_if.source  out_rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NumWords = (ARRAY_SIZE + WordW - 1) / WordW;
  localparam int AddrW = (NumWords > 1) ? $clog2(NumWords) : 1;

  cfg_t             cfg;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [WordW-1:0] mem_wdata, mem_rdata;

  brss_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  brss_ctrl #(.ArraySize(ARRAY_SIZE), .AddrW(AddrW)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .in_req(in_req), .out_rsp(out_rsp),
    .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
    .mem_re(mem_re), .mem_raddr(mem_raddr), .mem_rdata(mem_rdata)
  );

  brss_mem #(.Depth(NumWords), .AddrW(AddrW), .DataW(WordW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

`ifndef ASSERT_OFF
  a_clear_blocks: assert property (@(posedge clk) $past(!rst_n) |-> !in_req.ready)
    else $error("Request taken during the clearing pass.");
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready && in_req.req_type != REQ_QUERY) |=> !$rose(out_rsp.valid))
    else $error("Result raised right after a non-query request.");
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("Memory read and write issued in the same cycle.");
`endif

endmodule
